FILE: sv/sst_pkg.sv
// sst_pkg: shared constants, command and status codes, controller state and the
// per-cell control word for the small set table.
// No dependencies.
package sst_pkg;

   localparam int SstSize   = 32;
   localparam int DataW     = 32;
   localparam int CmdW      = 2;
   localparam int CountOutW = 6;
   localparam int StatusW   = 2;

   typedef enum logic [CmdW-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_CONTAINS = 2'd2,
      CMD_POP      = 2'd3
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic cmp_en;
      logic occupied;
      logic top;
      logic pop_mode;
      logic shift;
      logic insert;
   } cell_ctl_type;

endpackage

FILE: sv/sst_if.sv
// sst_if: valid/ready channels for command and result transactions.
// Depends on sst_pkg.
interface sst_req_if;
   logic                               valid;
   logic                               ready;
   logic        [sst_pkg::CmdW-1:0]    command;
   logic signed [sst_pkg::DataW-1:0]   value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface sst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [sst_pkg::DataW-1:0]     popped_value;
   logic        [sst_pkg::CountOutW-1:0] count;
   logic        [sst_pkg::StatusW-1:0]   status;

   modport source (output valid, output hit, output popped_value, output count,
                   output status, input ready);
   modport sink   (input valid, input hit, input popped_value, input count,
                   input status, output ready);
endinterface

FILE: sv/sst_cell.sv
// sst_cell: one table slot. Holds an entry, registers its compare result, loads the
// new value on an append and takes its upper neighbour's entry when the row closes a gap.
// Depends on sst_pkg.
module sst_cell (
   input  logic                              clock,
   input  sst_pkg::cell_ctl_type             ctl,
   input  logic signed [sst_pkg::DataW-1:0]  value,
   input  logic signed [sst_pkg::DataW-1:0]  upper,
   output logic signed [sst_pkg::DataW-1:0]  entry_ff,
   output logic                              match_ff
);

   logic signed [sst_pkg::DataW-1:0] entry_in;
   logic                             match_in;

   always_comb begin
      priority if (ctl.shift) begin
         entry_in = upper;
      end else if (ctl.insert) begin
         entry_in = value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_comb begin
      if (ctl.cmp_en) begin
         match_in = ctl.occupied & (ctl.pop_mode ? ctl.top : (entry_ff == value));
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

endmodule

FILE: sv/sst_ctrl.sv
// sst_ctrl: sequencer, hit/position encoding, fill count, per-cell control and
// the result register.
// Depends on sst_pkg and sst_if.
module sst_ctrl #(
   parameter int SIZE = sst_pkg::SstSize
) (
   input  logic                                        clock,
   input  logic                                        reset,
   sst_req_if.sink                                     req,
   sst_rsp_if.source                                   rsp,
   input  logic [SIZE-1:0]                             match,
   input  logic [SIZE-1:0][sst_pkg::DataW-1:0]         entries,
   output sst_pkg::cell_ctl_type [SIZE-1:0]            cell_ctl,
   output logic signed [sst_pkg::DataW-1:0]            value_ff
);

   localparam int CW = $clog2(SIZE + 1);
   localparam int PW = $clog2(SIZE);

   sst_pkg::state_type                  state_ff, state_in;
   logic [sst_pkg::CmdW-1:0]            cmd_ff;
   logic [CW-1:0]                       count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                hit_ff;
   logic signed [sst_pkg::DataW-1:0]    popped_ff;
   logic [sst_pkg::CountOutW-1:0]       count_out_ff;
   logic [sst_pkg::StatusW-1:0]         status_ff;

   sst_pkg::cmd_type                    cmd;
   sst_pkg::status_type                 status;
   logic                                accept, out_free, upd_fire;
   logic                                hit, ins_do, shift_do, count_full, count_zero;
   logic [sst_pkg::DataW-1:0]           sel_value;
   logic signed [sst_pkg::DataW-1:0]    popped;
   logic [PW-1:0]                       pos;

   assign accept   = req.valid & req.ready;
   assign out_free = ~rsp_valid_ff | rsp.ready;
   assign upd_fire = (state_ff == sst_pkg::ST_UPD) & out_free;
   assign cmd      = sst_pkg::cmd_type'(cmd_ff);

   // next state
   always_comb begin
      unique case (state_ff)
         sst_pkg::ST_IDLE: state_in = accept ? sst_pkg::ST_CMP : sst_pkg::ST_IDLE;
         sst_pkg::ST_CMP:  state_in = sst_pkg::ST_UPD;
         sst_pkg::ST_UPD: begin
            if (out_free) begin
               state_in = accept ? sst_pkg::ST_CMP : sst_pkg::ST_IDLE;
            end else begin
               state_in = sst_pkg::ST_UPD;
            end
         end
         default: state_in = sst_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      unique case (state_ff)
         sst_pkg::ST_IDLE: req.ready = 1'b1;
         sst_pkg::ST_UPD:  req.ready = out_free;
         default:          req.ready = 1'b0;
      endcase
   end

   // hit, selected entry and its position; at most one cell matches
   always_comb begin
      sel_value = '0;
      pos       = '0;
      for (int j = 0; j < SIZE; j++) begin
         sel_value = sel_value | (entries[j] & {sst_pkg::DataW{match[j]}});
         pos       = pos | (PW'(j) & {PW{match[j]}});
      end
   end

   assign hit        = |match;
   assign count_full = (count_ff == CW'(SIZE));
   assign count_zero = (count_ff == '0);

   always_comb begin
      ins_do   = 1'b0;
      shift_do = 1'b0;
      popped   = '0;
      status   = sst_pkg::STATUS_OK;
      unique case (cmd)
         sst_pkg::CMD_INSERT: begin
            ins_do = ~hit & ~count_full;
            if (~hit & count_full) begin
               status = sst_pkg::STATUS_FULL;
            end
         end
         sst_pkg::CMD_REMOVE: begin
            shift_do = hit;
            if (count_zero) begin
               status = sst_pkg::STATUS_EMPTY;
            end
         end
         sst_pkg::CMD_CONTAINS: begin
         end
         sst_pkg::CMD_POP: begin
            shift_do = hit;
            popped   = sel_value;
            if (count_zero) begin
               status = sst_pkg::STATUS_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (upd_fire) begin
         priority if (ins_do) begin
            count_in = count_ff + CW'(1);
         end else if (shift_do) begin
            count_in = count_ff - CW'(1);
         end else begin
            count_in = count_ff;
         end
      end
   end

   assign rsp_valid_in = upd_fire | (rsp_valid_ff & ~rsp.ready);

   for (genvar j = 0; j < SIZE; j++) begin : g_ctl
      localparam logic [CW-1:0] IdxC = CW'(j);
      localparam logic [PW-1:0] IdxP = PW'(j);
      always_comb begin
         cell_ctl[j].cmp_en   = (state_ff == sst_pkg::ST_CMP);
         cell_ctl[j].occupied = (IdxC < count_ff);
         cell_ctl[j].top      = (IdxC == (count_ff - CW'(1)));
         cell_ctl[j].pop_mode = (cmd == sst_pkg::CMD_POP);
         cell_ctl[j].shift    = upd_fire & shift_do & (IdxP >= pos);
         cell_ctl[j].insert   = upd_fire & ins_do & (IdxC == count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req.command;
         value_ff <= req.value;
      end
      if (upd_fire) begin
         hit_ff       <= hit;
         popped_ff    <= popped;
         count_out_ff <= sst_pkg::CountOutW'(count_in);
         status_ff    <= status;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hit          = hit_ff;
   assign rsp.popped_value = popped_ff;
   assign rsp.count        = count_out_ff;
   assign rsp.status       = status_ff;

endmodule

FILE: sv/small_set_table.sv
// small_set_table: set of up to SIZE distinct words kept packed in insertion order.
// Built from sst_ctrl and a row of sst_cell; depends on sst_pkg and sst_if.
//
//   channel | dir | transaction content
//   req     | in  | command, value
//   rsp     | out | hit, popped_value, count, status
//
// Each command runs in two steps: ST_CMP compares all cells in parallel, then ST_UPD
// updates the row (shift down / append) and loads the result register.
// A new command can also be taken in the update cycle, so the next compare needs no idle state.
// A stalled result register holds the update cycle, and with it req.ready.
// Synchronous reset empties the table; there is no clearing pass.
module small_set_table #(
   parameter int SIZE = sst_pkg::SstSize
) (
   input  logic        clock,
   input  logic        reset,
   sst_req_if.sink     req,
   sst_rsp_if.source   rsp
);

   logic [SIZE-1:0]                          match;
   logic [SIZE-1:0][sst_pkg::DataW-1:0]      entries;
   sst_pkg::cell_ctl_type [SIZE-1:0]         cell_ctl;
   logic signed [sst_pkg::DataW-1:0]         value;

   sst_ctrl #(
      .SIZE (SIZE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .rsp      (rsp),
      .match    (match),
      .entries  (entries),
      .cell_ctl (cell_ctl),
      .value_ff (value)
   );

   for (genvar j = 0; j < SIZE; j++) begin : g_cell
      logic signed [sst_pkg::DataW-1:0] upper;
      logic signed [sst_pkg::DataW-1:0] entry;

      if (j == SIZE - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid
         assign upper = entries[j+1];
      end

      sst_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[j]),
         .value    (value),
         .upper    (upper),
         .entry_ff (entry),
         .match_ff (match[j])
      );

      assign entries[j] = entry;
   end

endmodule
